[rtl/twpe_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// twpe_pkg
// Shared types, constants and helper functions of the access period end finder.
// ----------------------------------------------------------------------------
package twpe_pkg;

  localparam int TIME_BITS_DEF = 40;

  localparam int DAY_SECS    = 86400;
  localparam int HOUR_SECS   = 3600;
  // 86400 = 675 * 2^7: the low 7 bits pass through, the rest is reduced mod 675
  localparam int DAY_LO_BITS = 7;
  localparam int DAY_ODD     = 675;
  localparam int REM_BITS    = 10;
  localparam int CHUNK_BITS  = 8;
  localparam int CSUM_BITS   = 13;
  localparam int TSUM_BITS   = 16;
  localparam int RED_STEPS   = 6;
  localparam int ADDEND_BITS = 32;
  localparam int DAYS_BITS   = 4;
  localparam int HOURS_BITS  = 5;

  typedef enum logic [1:0] {
    KIND_OUT     = 2'd0,
    KIND_UNLIM   = 2'd1,
    KIND_BOUNDED = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    SEL_PT   = 2'd0,
    SEL_SOD  = 2'd1,
    SEL_DATE = 2'd2
  } base_sel_t;

  typedef enum logic [1:0] {
    ST_NONE      = 2'd0,
    ST_UNLIMITED = 2'd1,
    ST_BOUNDED   = 2'd2
  } status_t;

  // per-item control carried down the pipe
  typedef struct packed {
    kind_t                   kind;
    base_sel_t               sel;
    logic [ADDEND_BITS-1:0]  addend;
    logic                    last;
  } item_info_t;

  // 2^j mod 675, only ever called with constant j
  function automatic logic [REM_BITS-1:0] pow2_mod(input int unsigned j);
    int unsigned v;
    v = 1;
    for (int unsigned i = 0; i < j; i++) begin
      v = (v * 2) % DAY_ODD;
    end
    return REM_BITS'(v);
  endfunction

  function automatic logic [ADDEND_BITS-1:0] day_secs(input logic [DAYS_BITS-1:0] days);
    return ADDEND_BITS'(DAY_SECS * int'(days));
  endfunction

  function automatic logic [ADDEND_BITS-1:0] hour_secs(input logic [HOURS_BITS-1:0] hrs);
    return ADDEND_BITS'(HOUR_SECS * int'(hrs));
  endfunction

endpackage
`default_nettype wire

[rtl/twpe_classify.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// twpe_classify
// Decides the mode of one rule item, its in/out/unlimited kind, and the
// base and addend that make up its bounded end.
// ----------------------------------------------------------------------------
module twpe_classify import twpe_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  wire logic [TIME_BITS-1:0]        packet_time,
  input  wire logic [2:0]                  local_weekday,
  input  wire logic [4:0]                  local_hour,
  input  wire logic [31:0]                 item_duration,
  input  wire logic signed [TIME_BITS:0]   item_start_date,
  input  wire logic signed [TIME_BITS:0]   item_end_date,
  input  wire logic signed [3:0]           item_start_day,
  input  wire logic [2:0]                  item_end_day,
  input  wire logic signed [5:0]           item_start_hour,
  input  wire logic signed [5:0]           item_end_hour,
  input  wire logic                        last_item,
  output item_info_t                       info,
  output logic [TIME_BITS-1:0]             base
);

  logic signed [TIME_BITS:0] pt_s;
  logic sdate_none, edate_none, sday_none, shour_none, ehour_none;
  logic signed [4:0] wd_s, sd_s, ed_s, days_s;
  logic signed [6:0] hr_s, sh_s, eh_s;
  logic day_ok, hour_ok;

  assign pt_s       = $signed({1'b0, packet_time});
  assign sdate_none = &item_start_date;
  assign edate_none = &item_end_date;
  assign sday_none  = &item_start_day;
  assign shour_none = &item_start_hour;
  assign ehour_none = &item_end_hour;

  assign wd_s = $signed({2'b00, local_weekday});
  assign sd_s = 5'(item_start_day);
  assign ed_s = $signed({2'b00, item_end_day});
  assign hr_s = $signed({2'b00, local_hour});
  assign sh_s = 7'(item_start_hour);
  assign eh_s = 7'(item_end_hour);

  always_comb begin
    day_ok = 1'b0;
    days_s = '0;
    if (sd_s <= ed_s) begin
      day_ok = (wd_s >= sd_s) && (wd_s <= ed_s);
      days_s = ed_s - wd_s + 5'sd1;
    end else if (wd_s >= sd_s) begin
      // window wraps past Saturday
      day_ok = 1'b1;
      days_s = 5'sd7 - wd_s + ed_s;
    end else if (wd_s <= ed_s) begin
      day_ok = 1'b1;
      days_s = ed_s - wd_s + 5'sd1;
    end
  end

  assign hour_ok = (hr_s >= sh_s) && (ehour_none || (hr_s < eh_s));

  always_comb begin
    info.kind   = KIND_UNLIM;
    info.sel    = SEL_SOD;
    info.addend = '0;
    info.last   = last_item;
    base        = packet_time;
    if (item_duration != '0) begin
      info.kind   = KIND_BOUNDED;
      info.sel    = SEL_PT;
      info.addend = ADDEND_BITS'(item_duration);
    end else if (!sdate_none || !edate_none) begin
      if (!sdate_none && (item_start_date > pt_s)) begin
        info.kind = KIND_OUT;
      end else if (!edate_none) begin
        if (item_end_date >= pt_s) begin
          info.kind = KIND_BOUNDED;
          info.sel  = SEL_DATE;
          base      = item_end_date[TIME_BITS-1:0];
        end else begin
          info.kind = KIND_OUT;
        end
      end
    end else begin
      if (!sday_none) begin
        if (day_ok) begin
          info.kind   = KIND_BOUNDED;
          info.addend = day_secs(days_s[DAYS_BITS-1:0]);
        end else begin
          info.kind = KIND_OUT;
        end
      end
      if (!shour_none && (info.kind != KIND_OUT)) begin
        if (!hour_ok) begin
          info.kind = KIND_OUT;
        end else if (!ehour_none) begin
          // hour end replaces any day end
          info.kind   = KIND_BOUNDED;
          info.addend = hour_secs(item_end_hour[HOURS_BITS-1:0]);
        end
      end
    end
  end

endmodule
`default_nettype wire

[rtl/twpe_day_start.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// twpe_day_start
// Two-stage packet_time mod 86400 unit: weighted bit sums mod 675 per chunk,
// then a chunk total and a binary conditional-subtract reduction.
// ----------------------------------------------------------------------------
module twpe_day_start import twpe_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  ld_a,
  input  wire logic                  ld_b,
  input  wire logic [TIME_BITS-1:0]  base,
  output logic [REM_BITS-1:0]        rem
);

  localparam int HI_BITS = TIME_BITS - DAY_LO_BITS;
  localparam int NCHUNK  = (HI_BITS + CHUNK_BITS - 1) / CHUNK_BITS;
  localparam int PAD_W   = NCHUNK * CHUNK_BITS;

  logic [PAD_W-1:0]     hi_pad;
  logic [CSUM_BITS-1:0] csum_nxt [NCHUNK];
  logic [CSUM_BITS-1:0] csum_r   [NCHUNK];
  logic [TSUM_BITS-1:0] tsum;
  logic [TSUM_BITS-1:0] red;
  logic [REM_BITS-1:0]  rem_r;

  assign hi_pad = PAD_W'(base[TIME_BITS-1:DAY_LO_BITS]);

  always_comb begin
    for (int c = 0; c < NCHUNK; c++) begin
      csum_nxt[c] = '0;
      for (int b = 0; b < CHUNK_BITS; b++) begin
        csum_nxt[c] = csum_nxt[c] +
          (hi_pad[c*CHUNK_BITS+b] ? CSUM_BITS'(pow2_mod(c*CHUNK_BITS+b)) : CSUM_BITS'(0));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld_a) begin
      csum_r <= csum_nxt;
    end
  end

  // total stays below 64*675, so six steps leave the residue
  always_comb begin
    tsum = '0;
    for (int c = 0; c < NCHUNK; c++) begin
      tsum = tsum + TSUM_BITS'(csum_r[c]);
    end
    red = tsum;
    for (int k = RED_STEPS - 1; k >= 0; k--) begin
      if (red >= TSUM_BITS'(DAY_ODD << k)) begin
        red = red - TSUM_BITS'(DAY_ODD << k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld_b) begin
      rem_r <= red[REM_BITS-1:0];
    end
  end

  assign rem = rem_r;

endmodule
`default_nettype wire

[rtl/twpe_fold.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// twpe_fold
// Adds up each item's end, folds it into the running minimum and drop flag,
// and holds the period result in the output register.
// ----------------------------------------------------------------------------
module twpe_fold import twpe_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  item_valid,
  input  wire logic [TIME_BITS-1:0]  item_base,
  input  wire item_info_t            item_info,
  output logic                       item_ready,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [1:0]                 out_status,
  output logic [TIME_BITS:0]         out_end_time
);

  localparam int ACC_W = TIME_BITS + 2;

  logic [TIME_BITS:0]  end_sum;
  logic [ACC_W-1:0]    end_ext;
  logic [ACC_W-1:0]    acc_r, acc_upd;
  logic                dropped_r, dropped_upd;
  logic                out_valid_r;
  status_t             status_r, status_nxt;
  logic [TIME_BITS:0]  end_r, end_nxt;
  logic                out_free, adv;

  assign end_sum = (TIME_BITS+1)'(item_base) + (TIME_BITS+1)'(item_info.addend);
  assign end_ext = ACC_W'(end_sum);

  assign out_free   = !out_valid_r || !out_stall;
  // only a last item needs the output register
  assign item_ready = !item_info.last || out_free;
  assign adv        = item_valid && item_ready;

  always_comb begin
    dropped_upd = dropped_r || (item_info.kind == KIND_OUT);
    acc_upd     = acc_r;
    if ((item_info.kind == KIND_BOUNDED) && (end_ext < acc_r)) begin
      acc_upd = end_ext;
    end
    if (dropped_upd) begin
      status_nxt = ST_NONE;
      end_nxt    = '0;
    end else if (&acc_upd) begin
      status_nxt = ST_UNLIMITED;
      end_nxt    = '0;
    end else begin
      status_nxt = ST_BOUNDED;
      end_nxt    = acc_upd[TIME_BITS:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '1;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        if (item_info.last) begin
          acc_r     <= '1;
          dropped_r <= 1'b0;
        end else begin
          acc_r     <= acc_upd;
          dropped_r <= dropped_upd;
        end
      end
      if (adv && item_info.last) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && item_info.last) begin
      status_r <= status_nxt;
      end_r    <= end_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = status_r;
  assign out_end_time = end_r;

  a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (status_r != ST_BOUNDED)) |-> (end_r == '0))
    else $error("end time nonzero without bounded status");

  a_period_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && item_info.last) |=> ((&acc_r) && !dropped_r))
    else $error("period state not cleared after last item");

endmodule
`default_nettype wire

[rtl/time_window_period_end.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// time_window_period_end
// Streams the rule items of an access period and reports, at the last item,
// not-in-period, unlimited, or the earliest bounded end time.
// ----------------------------------------------------------------------------
// Pipeline from item accept to result valid: input register, two mod-86400
//   stages, day-start select, then end add and fold into output register.
// Throughput: 1 item per cycle unless out_stall holds back a last item; the running minimum folds one item a cycle.
// Reset: synchronous active-low; clears pipe valids, output valid, drop flag,
//   and sets the running minimum to all ones (unlimited).
// ----------------------------------------------------------------------------
module time_window_period_end import twpe_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [TIME_BITS-1:0]        in_packet_time,
  input  wire logic [2:0]                  in_local_weekday,
  input  wire logic [4:0]                  in_local_hour,
  input  wire logic [31:0]                 in_item_duration,
  input  wire logic signed [TIME_BITS:0]   in_item_start_date,
  input  wire logic signed [TIME_BITS:0]   in_item_end_date,
  input  wire logic signed [3:0]           in_item_start_day,
  input  wire logic [2:0]                  in_item_end_day,
  input  wire logic signed [5:0]           in_item_start_hour,
  input  wire logic signed [5:0]           in_item_end_hour,
  input  wire logic                        in_last_item,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [1:0]                       out_period_status,
  output logic [TIME_BITS:0]               out_period_end_time
);

  localparam int HI_BITS = TIME_BITS - DAY_LO_BITS;

  // stage 1: input register
  logic                        v1_r;
  logic [TIME_BITS-1:0]        pt1_r;
  logic [2:0]                  wday1_r;
  logic [4:0]                  hour1_r;
  logic [31:0]                 dur1_r;
  logic signed [TIME_BITS:0]   sdate1_r, edate1_r;
  logic signed [3:0]           sday1_r;
  logic [2:0]                  eday1_r;
  logic signed [5:0]           shour1_r, ehour1_r;
  logic                        last1_r;

  item_info_t            info1, info2_r, info3_r, info4_r;
  logic [TIME_BITS-1:0]  base1, base2_r, base3_r, a4_r;
  logic                  v2_r, v3_r, v4_r;
  logic [REM_BITS-1:0]   rem3;
  logic [TIME_BITS-1:0]  sod3, a3;
  logic                  fold_rdy;
  logic                  rdy1, rdy2, rdy3, rdy4;

  assign rdy4 = !v4_r || fold_rdy;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_stall = !rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      pt1_r    <= in_packet_time;
      wday1_r  <= in_local_weekday;
      hour1_r  <= in_local_hour;
      dur1_r   <= in_item_duration;
      sdate1_r <= in_item_start_date;
      edate1_r <= in_item_end_date;
      sday1_r  <= in_item_start_day;
      eday1_r  <= in_item_end_day;
      shour1_r <= in_item_start_hour;
      ehour1_r <= in_item_end_hour;
      last1_r  <= in_last_item;
    end
  end

  twpe_classify #(.TIME_BITS(TIME_BITS)) u_classify (
    .packet_time     (pt1_r),
    .local_weekday   (wday1_r),
    .local_hour      (hour1_r),
    .item_duration   (dur1_r),
    .item_start_date (sdate1_r),
    .item_end_date   (edate1_r),
    .item_start_day  (sday1_r),
    .item_end_day    (eday1_r),
    .item_start_hour (shour1_r),
    .item_end_hour   (ehour1_r),
    .last_item       (last1_r),
    .info            (info1),
    .base            (base1)
  );

  twpe_day_start #(.TIME_BITS(TIME_BITS)) u_day_start (
    .clk  (clk),
    .ld_a (rdy2 && v1_r),
    .ld_b (rdy3 && v2_r),
    .base (base1),
    .rem  (rem3)
  );

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      info2_r <= info1;
      base2_r <= base1;
    end
    if (rdy3 && v2_r) begin
      info3_r <= info2_r;
      base3_r <= base2_r;
    end
    if (rdy4 && v3_r) begin
      info4_r <= info3_r;
      a4_r    <= a3;
    end
  end

  // UTC day start: drop the residue mod 675 above the low 7 bits, clear those
  assign sod3 = {base3_r[TIME_BITS-1:DAY_LO_BITS] - HI_BITS'(rem3), {DAY_LO_BITS{1'b0}}};

  always_comb begin
    case (info3_r.sel)
      SEL_SOD:  a3 = sod3;
      SEL_PT:   a3 = base3_r;
      SEL_DATE: a3 = base3_r;
      default:  a3 = base3_r;
    endcase
  end

  twpe_fold #(.TIME_BITS(TIME_BITS)) u_fold (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (v4_r),
    .item_base    (a4_r),
    .item_info    (info4_r),
    .item_ready   (fold_rdy),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_status   (out_period_status),
    .out_end_time (out_period_end_time)
  );

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> (rem3 < REM_BITS'(DAY_ODD)))
    else $error("day residue out of range");

  a_sod_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (v4_r && (info4_r.sel == SEL_SOD)) |-> (a4_r[DAY_LO_BITS-1:0] == '0))
    else $error("day start not aligned");

endmodule
`default_nettype wire
